[hdl/pcu_pkg.sv]
// Shared package of the Pearson correlation unit: widths, status codes,
// sequencer state types and the request/response bundles of the multiplier.
// Depends on nothing.
`default_nettype none

package pcu_pkg;

    // Largest number of pairs accumulated in one set.
    localparam logic [16:0] MAX_PAIRS = 17'h10000;

    // Result status codes.
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_ZERO_DEN = 2'd1;
    localparam logic [1:0] STAT_OVERFLOW = 2'd2;

    // Multiplier operand and product widths (32-bit limbs).
    localparam int A_W    = 128;
    localparam int B_W    = 64;
    localparam int PROD_W = 192;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_SRCH,
        S_EMIT
    } state_t;

    // Which product the sequencer is forming.
    typedef enum logic [3:0] {
        OP_XX,
        OP_YY,
        OP_XY,
        OP_SXX,
        OP_NXX,
        OP_SYY,
        OP_NYY,
        OP_SXY,
        OP_NXY,
        OP_MAG2,
        OP_DPROD,
        OP_KK,
        OP_KD
    } step_t;

    typedef struct packed {
        logic             start;
        logic [A_W-1:0]   a;
        logic [B_W-1:0]   b;
        logic [1:0]       a_limbs_m1;
        logic             b_limbs_m1;
    } mul_req_t;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] prod;
    } mul_rsp_t;

endpackage

`default_nettype wire

[hdl/pearson_correlation_unit.sv]
// Top level of the Pearson correlation unit: sequencer, running sums,
// result search and output register. Depends on pcu_pkg and pcu_mul.
//
//  Channel  Direction  Payload
//  s_*      in         tdata = x_sample[15:0], y_sample[31:16]; tlast = last
//  m_*      out        tdata = correlation[15:0], status[17:16],
//                              sample_count[34:18], zero pad [39:35]
//
// A pair that is not last is accepted, then takes three single-limb products,
// each by issue, form, accumulate and collect. A last pair adds eight
// further products and a search on r of at most 16 steps (k*k, then k*k
// times the variance product). Reset clears the count, sums and sequencer.
// The input stalls while a pair is in work; a result held in the output
// register does not stall input until the next result is ready.
`default_nettype none

module pearson_correlation_unit
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // x_sample[15:0], y_sample[31:16]
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata    // correlation[15:0], status[17:16],
                                        // sample_count[34:18]
);

    pcu_pkg::state_t   state_reg, state_next;
    pcu_pkg::step_t    step_reg, step_next;
    pcu_pkg::mul_req_t mreq;
    pcu_pkg::mul_rsp_t mrsp;

    logic [16:0]          pair_count_reg, pair_count_next;
    logic signed [32:0]   sum_x_reg, sum_x_next;
    logic signed [32:0]   sum_y_reg, sum_y_next;
    logic [46:0]          sum_xx_reg, sum_xx_next;
    logic [46:0]          sum_yy_reg, sum_yy_next;
    logic signed [47:0]   sum_xy_reg, sum_xy_next;
    logic                 ovf_reg, ovf_next;

    logic [15:0]  xm_reg, xm_next;
    logic [15:0]  ym_reg, ym_next;
    logic         xs_reg, xs_next;
    logic         ys_reg, ys_next;
    logic         last_reg, last_next;

    logic [63:0]  t_reg, t_next;
    logic [63:0]  dx_reg, dx_next;
    logic [63:0]  dy_reg, dy_next;
    logic [63:0]  mag_reg, mag_next;
    logic         neg_reg, neg_next;
    logic [127:0] lhs_reg, lhs_next;
    logic [127:0] dprod_reg, dprod_next;
    logic [16:0]  lo_reg, lo_next;
    logic [16:0]  hi_reg, hi_next;
    logic [16:0]  q_reg, q_next;
    logic [16:0]  k_reg, k_next;
    logic [31:0]  kk_reg, kk_next;
    logic [15:0]  res_corr_reg, res_corr_next;
    logic [1:0]   res_stat_reg, res_stat_next;

    logic         out_vld_reg, out_vld_next;
    logic [15:0]  out_corr_reg, out_corr_next;
    logic [1:0]   out_stat_reg, out_stat_next;
    logic [16:0]  out_cnt_reg, out_cnt_next;

    logic         in_acc;
    logic [15:0]  x_in, y_in;
    logic [31:0]  sxm, sym;
    logic [46:0]  sxym;
    logic [63:0]  p64;
    logic [63:0]  nv, num;
    logic [17:0]  q_sum;
    logic [32:0]  pxy;

    assign x_in   = s_tdata[15:0];
    assign y_in   = s_tdata[31:16];
    assign in_acc = s_tvalid && s_tready;

    // Magnitudes of the signed sums.
    assign sxm  = sum_x_reg[32] ? 32'(-sum_x_reg) : sum_x_reg[31:0];
    assign sym  = sum_y_reg[32] ? 32'(-sum_y_reg) : sum_y_reg[31:0];
    assign sxym = sum_xy_reg[47] ? 47'(-sum_xy_reg) : sum_xy_reg[46:0];
    assign p64  = mrsp.prod[63:0];
    assign nv   = sum_xy_reg[47] ? -p64 : p64;
    assign num  = nv - t_reg;
    assign q_sum = 18'(lo_reg) + 18'(hi_reg) + 18'd1;
    assign pxy  = (xs_reg ^ ys_reg) ? -{1'b0, p64[31:0]} : {1'b0, p64[31:0]};

    pcu_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .rsp   (mrsp)
    );

    // Operand selection for the product of the current step.
    always_comb
    begin
        mreq.start      = (state_reg == pcu_pkg::S_ISSUE);
        mreq.a          = '0;
        mreq.b          = '0;
        mreq.a_limbs_m1 = 2'd0;
        mreq.b_limbs_m1 = 1'b0;
        case (step_reg)
            pcu_pkg::OP_XX:
            begin
                mreq.a = 128'(xm_reg);
                mreq.b = 64'(xm_reg);
            end
            pcu_pkg::OP_YY:
            begin
                mreq.a = 128'(ym_reg);
                mreq.b = 64'(ym_reg);
            end
            pcu_pkg::OP_XY:
            begin
                mreq.a = 128'(xm_reg);
                mreq.b = 64'(ym_reg);
            end
            pcu_pkg::OP_SXX:
            begin
                mreq.a = 128'(sxm);
                mreq.b = 64'(sxm);
            end
            pcu_pkg::OP_SYY:
            begin
                mreq.a = 128'(sym);
                mreq.b = 64'(sym);
            end
            pcu_pkg::OP_NXX:
            begin
                mreq.a          = 128'(sum_xx_reg);
                mreq.b          = 64'(pair_count_reg);
                mreq.a_limbs_m1 = 2'd1;
            end
            pcu_pkg::OP_NYY:
            begin
                mreq.a          = 128'(sum_yy_reg);
                mreq.b          = 64'(pair_count_reg);
                mreq.a_limbs_m1 = 2'd1;
            end
            pcu_pkg::OP_SXY:
            begin
                mreq.a = 128'(sxm);
                mreq.b = 64'(sym);
            end
            pcu_pkg::OP_NXY:
            begin
                mreq.a          = 128'(sxym);
                mreq.b          = 64'(pair_count_reg);
                mreq.a_limbs_m1 = 2'd1;
            end
            pcu_pkg::OP_MAG2:
            begin
                mreq.a          = 128'(mag_reg);
                mreq.b          = mag_reg;
                mreq.a_limbs_m1 = 2'd1;
                mreq.b_limbs_m1 = 1'b1;
            end
            pcu_pkg::OP_DPROD:
            begin
                mreq.a          = 128'(dx_reg);
                mreq.b          = dy_reg;
                mreq.a_limbs_m1 = 2'd1;
                mreq.b_limbs_m1 = 1'b1;
            end
            pcu_pkg::OP_KK:
            begin
                mreq.a = 128'(k_reg);
                mreq.b = 64'(k_reg);
            end
            pcu_pkg::OP_KD:
            begin
                mreq.a          = dprod_reg;
                mreq.b          = 64'(kk_reg);
                mreq.a_limbs_m1 = 2'd3;
            end
            default:
            begin
                mreq.a = '0;
            end
        endcase
    end

    // Sequencer: next state and datapath updates.
    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        pair_count_next = pair_count_reg;
        sum_x_next      = sum_x_reg;
        sum_y_next      = sum_y_reg;
        sum_xx_next     = sum_xx_reg;
        sum_yy_next     = sum_yy_reg;
        sum_xy_next     = sum_xy_reg;
        ovf_next        = ovf_reg;
        xm_next         = xm_reg;
        ym_next         = ym_reg;
        xs_next         = xs_reg;
        ys_next         = ys_reg;
        last_next       = last_reg;
        t_next          = t_reg;
        dx_next         = dx_reg;
        dy_next         = dy_reg;
        mag_next        = mag_reg;
        neg_next        = neg_reg;
        lhs_next        = lhs_reg;
        dprod_next      = dprod_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        q_next          = q_reg;
        k_next          = k_reg;
        kk_next         = kk_reg;
        res_corr_next   = res_corr_reg;
        res_stat_next   = res_stat_reg;
        out_vld_next    = out_vld_reg && !m_tready;
        out_corr_next   = out_corr_reg;
        out_stat_next   = out_stat_reg;
        out_cnt_next    = out_cnt_reg;
        s_tready        = (state_reg == pcu_pkg::S_IDLE);

        case (state_reg)
            pcu_pkg::S_IDLE:
            begin
                if (in_acc)
                begin
                    last_next = s_tlast;
                    xs_next   = x_in[15];
                    ys_next   = y_in[15];
                    xm_next   = x_in[15] ? -x_in : x_in;
                    ym_next   = y_in[15] ? -y_in : y_in;
                    if (pair_count_reg == pcu_pkg::MAX_PAIRS)
                    begin
                        ovf_next = 1'b1;
                        if (s_tlast)
                        begin
                            res_corr_next = '0;
                            res_stat_next = pcu_pkg::STAT_OVERFLOW;
                            state_next    = pcu_pkg::S_EMIT;
                        end
                    end
                    else
                    begin
                        pair_count_next = pair_count_reg + 17'd1;
                        sum_x_next      = sum_x_reg + {{17{x_in[15]}}, x_in};
                        sum_y_next      = sum_y_reg + {{17{y_in[15]}}, y_in};
                        step_next       = pcu_pkg::OP_XX;
                        state_next      = pcu_pkg::S_ISSUE;
                    end
                end
            end

            pcu_pkg::S_ISSUE:
            begin
                state_next = pcu_pkg::S_WAIT;
            end

            pcu_pkg::S_WAIT:
            begin
                if (mrsp.done)
                begin
                    state_next = pcu_pkg::S_ISSUE;
                    case (step_reg)
                        pcu_pkg::OP_XX:
                        begin
                            sum_xx_next = sum_xx_reg + 47'(p64[31:0]);
                            step_next   = pcu_pkg::OP_YY;
                        end
                        pcu_pkg::OP_YY:
                        begin
                            sum_yy_next = sum_yy_reg + 47'(p64[31:0]);
                            step_next   = pcu_pkg::OP_XY;
                        end
                        pcu_pkg::OP_XY:
                        begin
                            sum_xy_next = sum_xy_reg + {{15{pxy[32]}}, pxy};
                            if (last_reg && ovf_reg)
                            begin
                                res_corr_next = '0;
                                res_stat_next = pcu_pkg::STAT_OVERFLOW;
                                state_next    = pcu_pkg::S_EMIT;
                            end
                            else if (last_reg)
                            begin
                                step_next = pcu_pkg::OP_SXX;
                            end
                            else
                            begin
                                state_next = pcu_pkg::S_IDLE;
                            end
                        end
                        pcu_pkg::OP_SXX:
                        begin
                            t_next    = p64;
                            step_next = pcu_pkg::OP_NXX;
                        end
                        pcu_pkg::OP_NXX:
                        begin
                            dx_next   = p64 - t_reg;
                            step_next = pcu_pkg::OP_SYY;
                        end
                        pcu_pkg::OP_SYY:
                        begin
                            t_next    = p64;
                            step_next = pcu_pkg::OP_NYY;
                        end
                        pcu_pkg::OP_NYY:
                        begin
                            dy_next   = p64 - t_reg;
                            step_next = pcu_pkg::OP_SXY;
                        end
                        pcu_pkg::OP_SXY:
                        begin
                            t_next    = (sum_x_reg[32] ^ sum_y_reg[32]) ? -p64 : p64;
                            step_next = pcu_pkg::OP_NXY;
                        end
                        pcu_pkg::OP_NXY:
                        begin
                            neg_next = num[63];
                            mag_next = num[63] ? -num : num;
                            if ((dx_reg == 64'd0) || (dy_reg == 64'd0))
                            begin
                                res_corr_next = '0;
                                res_stat_next = pcu_pkg::STAT_ZERO_DEN;
                                state_next    = pcu_pkg::S_EMIT;
                            end
                            else
                            begin
                                step_next = pcu_pkg::OP_MAG2;
                            end
                        end
                        pcu_pkg::OP_MAG2:
                        begin
                            lhs_next  = mrsp.prod[127:0];
                            step_next = pcu_pkg::OP_DPROD;
                        end
                        pcu_pkg::OP_DPROD:
                        begin
                            dprod_next = mrsp.prod[127:0];
                            lo_next    = 17'd0;
                            hi_next    = 17'h08000;
                            state_next = pcu_pkg::S_SRCH;
                        end
                        pcu_pkg::OP_KK:
                        begin
                            kk_next   = p64[31:0];
                            step_next = pcu_pkg::OP_KD;
                        end
                        pcu_pkg::OP_KD:
                        begin
                            // Keep q when (2q-1)^2 * dx * dy <= (65536 * mag)^2.
                            if (mrsp.prod[159:0] <= {lhs_reg, 32'b0})
                            begin
                                lo_next = q_reg;
                            end
                            else
                            begin
                                hi_next = q_reg - 17'd1;
                            end
                            state_next = pcu_pkg::S_SRCH;
                        end
                        default:
                        begin
                            state_next = pcu_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            pcu_pkg::S_SRCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    q_next     = q_sum[17:1];
                    k_next     = {q_sum[16:1], 1'b0} - 17'd1;
                    step_next  = pcu_pkg::OP_KK;
                    state_next = pcu_pkg::S_ISSUE;
                end
                else
                begin
                    // Apply the sign; plus one saturates to the largest code.
                    if (neg_reg)
                    begin
                        res_corr_next = 16'(-lo_reg);
                    end
                    else if (lo_reg[15])
                    begin
                        res_corr_next = 16'h7FFF;
                    end
                    else
                    begin
                        res_corr_next = lo_reg[15:0];
                    end
                    res_stat_next = pcu_pkg::STAT_OK;
                    state_next    = pcu_pkg::S_EMIT;
                end
            end

            pcu_pkg::S_EMIT:
            begin
                if (!out_vld_reg || m_tready)
                begin
                    out_vld_next    = 1'b1;
                    out_corr_next   = res_corr_reg;
                    out_stat_next   = res_stat_reg;
                    out_cnt_next    = pair_count_reg;
                    pair_count_next = '0;
                    sum_x_next      = '0;
                    sum_y_next      = '0;
                    sum_xx_next     = '0;
                    sum_yy_next     = '0;
                    sum_xy_next     = '0;
                    ovf_next        = 1'b0;
                    state_next      = pcu_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = pcu_pkg::S_IDLE;
            end
        endcase
    end

    // Control state and running sums.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pcu_pkg::S_IDLE;
            step_reg       <= pcu_pkg::OP_XX;
            pair_count_reg <= '0;
            sum_x_reg      <= '0;
            sum_y_reg      <= '0;
            sum_xx_reg     <= '0;
            sum_yy_reg     <= '0;
            sum_xy_reg     <= '0;
            ovf_reg        <= 1'b0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            pair_count_reg <= pair_count_next;
            sum_x_reg      <= sum_x_next;
            sum_y_reg      <= sum_y_next;
            sum_xx_reg     <= sum_xx_next;
            sum_yy_reg     <= sum_yy_next;
            sum_xy_reg     <= sum_xy_next;
            ovf_reg        <= ovf_next;
            out_vld_reg    <= out_vld_next;
        end
    end

    // Working registers of the current item and set.
    always_ff @(posedge clk)
    begin
        xm_reg       <= xm_next;
        ym_reg       <= ym_next;
        xs_reg       <= xs_next;
        ys_reg       <= ys_next;
        last_reg     <= last_next;
        t_reg        <= t_next;
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        lhs_reg      <= lhs_next;
        dprod_reg    <= dprod_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        q_reg        <= q_next;
        k_reg        <= k_next;
        kk_reg       <= kk_next;
        res_corr_reg <= res_corr_next;
        res_stat_reg <= res_stat_next;
        out_corr_reg <= out_corr_next;
        out_stat_reg <= out_stat_next;
        out_cnt_reg  <= out_cnt_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {5'b0, out_cnt_reg, out_stat_reg, out_corr_reg};

    // The multiplier only answers while the sequencer is waiting for it.
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mrsp.done |-> state_reg == pcu_pkg::S_WAIT)
        else $error("multiplier result arrived outside the wait state");

    // The count never passes the set limit.
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        pair_count_reg <= pcu_pkg::MAX_PAIRS)
        else $error("pair count beyond limit");

    // Error results carry a zero coefficient.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && (out_stat_reg == pcu_pkg::STAT_OVERFLOW
            || out_stat_reg == pcu_pkg::STAT_ZERO_DEN)) |-> out_corr_reg == 16'd0)
        else $error("error result with non-zero coefficient");

    // A set is cleared together with the loading of its result.
    a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pcu_pkg::S_EMIT && state_next == pcu_pkg::S_IDLE)
            |=> (pair_count_reg == 17'd0 && !ovf_reg))
        else $error("set not cleared after result");

endmodule

`default_nettype wire

[hdl/pcu_mul.sv]
// Shared multi-limb unsigned multiplier: one 32x32 product per cycle,
// registered, then added into a wide accumulator at its limb offset.
// Depends on pcu_pkg.
`default_nettype none

module pcu_mul
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire pcu_pkg::mul_req_t req,
    output pcu_pkg::mul_rsp_t      rsp
);

    logic                        busy_reg, busy_next;
    logic [1:0]                  i_reg, i_next;
    logic                        j_reg, j_next;
    logic [63:0]                 pp_reg, pp_next;
    logic [2:0]                  sh_reg, sh_next;
    logic                        pp_vld_reg, pp_vld_next;
    logic                        pp_last_reg, pp_last_next;
    logic [pcu_pkg::PROD_W-1:0]  acc_reg, acc_next;
    logic                        done_reg, done_next;
    logic [31:0]                 a_limb;
    logic [31:0]                 b_limb;
    logic                        last_pair;

    // Limb selection for the current partial product.
    assign a_limb    = req.a[{i_reg, 5'b0} +: 32];
    assign b_limb    = req.b[{j_reg, 5'b0} +: 32];
    assign last_pair = (i_reg == req.a_limbs_m1) && (j_reg == req.b_limbs_m1);

    // Limb walk, partial product stage and accumulation.
    always_comb
    begin
        busy_next    = busy_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        pp_next      = pp_reg;
        sh_next      = sh_reg;
        pp_vld_next  = 1'b0;
        pp_last_next = 1'b0;
        acc_next     = acc_reg;
        done_next    = pp_vld_reg && pp_last_reg;

        if (pp_vld_reg)
        begin
            acc_next = acc_reg + (pcu_pkg::PROD_W'(pp_reg) << {sh_reg, 5'b0});
        end

        if (req.start)
        begin
            busy_next = 1'b1;
            i_next    = 2'd0;
            j_next    = 1'b0;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            pp_next      = {32'b0, a_limb} * {32'b0, b_limb};
            sh_next      = 3'(i_reg) + 3'(j_reg);
            pp_vld_next  = 1'b1;
            pp_last_next = last_pair;
            if (last_pair)
            begin
                busy_next = 1'b0;
            end
            if (j_reg == req.b_limbs_m1)
            begin
                j_next = 1'b0;
                i_next = i_reg + 2'd1;
            end
            else
            begin
                j_next = j_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            i_reg       <= 2'd0;
            j_reg       <= 1'b0;
            pp_vld_reg  <= 1'b0;
            pp_last_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            busy_reg    <= busy_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            pp_vld_reg  <= pp_vld_next;
            pp_last_reg <= pp_last_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pp_reg  <= pp_next;
        sh_reg  <= sh_next;
        acc_reg <= acc_next;
    end

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;

endmodule

`default_nettype wire

[bench/tb_top.sv]
// Self-checking testbench for the Pearson correlation unit: a predictor with exact wide
// integer arithmetic checks every result against the block. Depends on pcu_pkg and the RTL.
`default_nettype none

class corr_scoreboard;
    // Running state of the current data set.
    logic [16:0]  pairs_held;
    longint       acc_x;
    longint       acc_y;
    logic [63:0]  acc_xx;
    logic [63:0]  acc_yy;
    longint       acc_xy;
    bit           count_overflowed;
    // Expected results, oldest first: correlation, status, sample count.
    logic [34:0]  results_due[$];
    int           fails;

    function void clear_set();
        pairs_held       = '0;
        acc_x            = 0;
        acc_y            = 0;
        acc_xx           = '0;
        acc_yy           = '0;
        acc_xy           = 0;
        count_overflowed = 0;
    endfunction

    function logic [15:0] coefficient(output logic [1:0] stat);
        logic [63:0]  n;
        logic [63:0]  ax;
        logic [63:0]  ay;
        logic [63:0]  dx;
        logic [63:0]  dy;
        logic [63:0]  num;
        logic [63:0]  mag;
        logic [63:0]  k;
        logic [191:0] lhs;
        logic [191:0] dprod;
        logic [191:0] rhs;
        int unsigned  lo;
        int unsigned  hi;
        int unsigned  q;
        bit           neg;
        n   = 64'(pairs_held);
        ax  = acc_x < 0 ? 64'(-acc_x) : 64'(acc_x);
        ay  = acc_y < 0 ? 64'(-acc_y) : 64'(acc_y);
        dx  = n * acc_xx - ax * ax;
        dy  = n * acc_yy - ay * ay;
        num = n * 64'(acc_xy) - 64'(acc_x * acc_y);
        neg = num[63];
        mag = neg ? (~num + 64'd1) : num;
        if (dx == 0 || dy == 0)
        begin
            stat = pcu_pkg::STAT_ZERO_DEN;
            return 16'd0;
        end
        stat  = pcu_pkg::STAT_OK;
        lhs   = (192'(mag) * 192'(mag)) << 32;
        dprod = 192'(dx) * 192'(dy);
        lo    = 0;
        hi    = 32768;
        // Largest q with (2q-1)^2 * dx * dy no greater than (65536 * mag)^2.
        while (lo < hi)
        begin
            q   = (lo + hi + 1) / 2;
            k   = 64'(2 * q - 1);
            rhs = 192'(k * k) * dprod;
            if (rhs <= lhs)
                lo = q;
            else
                hi = q - 1;
        end
        if (!neg)
            return lo > 32767 ? 16'h7fff : 16'(lo);
        return 16'(-int'(lo));
    endfunction

    // An accepted pair: accumulate it and, on the last one, work out the result.
    function void note_pair(logic [15:0] xs, logic [15:0] ys, bit last_pair);
        longint      xv;
        longint      yv;
        logic [15:0] corr;
        logic [1:0]  stat;
        xv = longint'($signed(xs));
        yv = longint'($signed(ys));
        if (pairs_held < pcu_pkg::MAX_PAIRS)
        begin
            pairs_held = pairs_held + 17'd1;
            acc_x      += xv;
            acc_y      += yv;
            acc_xx     += 64'(xv * xv);
            acc_yy     += 64'(yv * yv);
            acc_xy     += xv * yv;
        end
        else
            count_overflowed = 1;
        if (!last_pair)
            return;
        if (count_overflowed)
        begin
            corr = '0;
            stat = pcu_pkg::STAT_OVERFLOW;
        end
        else
            corr = coefficient(stat);
        results_due.insert(results_due.size(), {pairs_held, stat, corr});
        clear_set();
    endfunction

    // An accepted result: compare it field by field with the oldest expectation.
    function void check_result(logic [39:0] word);
        logic [34:0] due;
        if (results_due.size() == 0)
        begin
            $error("unexpected result %h", word);
            fails++;
            return;
        end
        due = results_due.pop_front();
        if (word[15:0] !== due[15:0])
        begin
            $error("correlation: expected %h, got %h", due[15:0], word[15:0]);
            fails++;
        end
        if (word[17:16] !== due[17:16])
        begin
            $error("status: expected %0d, got %0d", due[17:16], word[17:16]);
            fails++;
        end
        if (word[34:18] !== due[34:18])
        begin
            $error("sample_count: expected %0d, got %0d", due[34:18], word[34:18]);
            fails++;
        end
    endfunction
endclass

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint CYCLE_LIMIT = 4000000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;

    corr_scoreboard sb;
    longint         cycles;
    int             hold_request;
    int             hold_left;
    int             ready_mode;
    int             burst_left;
    bit             steady_send;

    pearson_correlation_unit u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 clk = ~clk;

    // Timeout guard.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result monitor.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // Receiver: stall pattern of its own, plus one long hold-off on request.
    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if ((cycles % 97) == 0)
            ready_mode = $urandom_range(0, 2);
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (ready_mode == 0)
            m_tready <= 1'b1;
        else if (ready_mode == 1)
            m_tready <= ($urandom_range(0, 1) == 1);
        else
            m_tready <= ($urandom_range(0, 9) < 8);
    end

    // Offer one pair and wait for it to be taken; returns at a falling edge.
    task automatic send_pair(logic [15:0] xs, logic [15:0] ys, bit last_pair);
        s_tdata  <= {ys, xs};
        s_tlast  <= last_pair;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_pair(xs, ys, last_pair);
        @(negedge clk);
        if (steady_send)
            return;
        burst_left--;
        if (burst_left <= 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            burst_left = $urandom_range(1, 20);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.results_due.size() != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
    endtask

    // One data set of random shape and content.
    task automatic send_random_set(int pairs);
        int          shape;
        int          noise;
        logic [15:0] xs;
        logic [15:0] ys;
        shape = $urandom_range(0, 5);
        for (int i = 0; i < pairs; i++)
        begin
            xs    = 16'($urandom_range(0, 65535));
            noise = $urandom_range(0, 2000) - 1000;
            case (shape)
                0:       ys = xs;
                1:       ys = ~xs;
                2:       ys = (int'($signed(xs)) + noise > 32767 ||
                               int'($signed(xs)) + noise < -32768) ?
                              xs : 16'(int'($signed(xs)) + noise);
                3:       ys = 16'($urandom_range(0, 3)) + 16'hfffe;
                default: ys = 16'($urandom_range(0, 65535));
            endcase
            send_pair(xs, ys, i == pairs - 1);
        end
    endtask

    initial
    begin
        int sets;
        sb = new();
        sb.clear_set();
        clk          = 1'b0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        m_tready     = 1'b0;
        cycles       = 0;
        hold_request = 0;
        hold_left    = 0;
        ready_mode   = 0;
        burst_left   = 4;
        steady_send  = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: a single pair, constant variables, extremes, exact +1 and -1.
        send_pair(16'h1234, 16'h4321, 1);
        send_pair(16'h0005, 16'h8000, 0);
        send_pair(16'h0005, 16'h7fff, 1);
        send_pair(16'h8000, 16'h8000, 0);
        send_pair(16'h7fff, 16'h7fff, 1);
        send_pair(16'h8000, 16'h7fff, 0);
        send_pair(16'h7fff, 16'h8000, 1);
        send_pair(16'h8000, 16'h8000, 0);
        send_pair(16'h8000, 16'h8000, 0);
        send_pair(16'h7fff, 16'h7fff, 0);
        send_pair(16'h0000, 16'hffff, 1);
        send_pair(16'hffff, 16'h0001, 0);
        send_pair(16'h0001, 16'h0003, 0);
        send_pair(16'h0003, 16'h0002, 0);
        send_pair(16'h0000, 16'h0000, 1);
        send_pair(16'h5555, 16'haaaa, 0);
        send_pair(16'haaaa, 16'h5555, 1);
        wait_drained();

        // Random sets, mostly short; a long receiver hold-off and a full drain midway.
        sets = 0;
        while (sets < 215)
        begin
            if (sets == 40)
                hold_request = 3000;
            if (sets == 120)
                wait_drained();
            steady_send = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 15) == 0)
                send_random_set($urandom_range(20, 60));
            else
                send_random_set($urandom_range(1, 10));
            sets++;
        end
        steady_send = 0;

        wait_drained();
        if (sb.fails == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

`default_nettype wire

[filelist.f]
hdl/pcu_pkg.sv
hdl/pcu_mul.sv
hdl/pearson_correlation_unit.sv
bench/tb_top.sv
